### sv/rtsc_pkg.sv
package rtsc_pkg;

    // converter and arithmetic sizing
    localparam int ADC_W     = 12;
    localparam int ADC_BITS  = 12;
    localparam int DROP_BITS = 4;
    localparam int CFG_W     = 8;
    localparam int VAL_W     = ADC_W - DROP_BITS;
    localparam int D_W       = (VAL_W > CFG_W) ? VAL_W : CFG_W;
    localparam int PROD_W    = D_W + CFG_W;
    localparam int CNT_W     = $clog2(PROD_W);
    localparam logic [ADC_W-1:0] ADC_MASK = ADC_W'((64'd1 << ADC_BITS) - 64'd1);

    // configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_SETTLE_TICKS = 3'd0;
    localparam logic [IDX_W-1:0] REG_X_FLOOR      = 3'd1;
    localparam logic [IDX_W-1:0] REG_X_CEILING    = 3'd2;
    localparam logic [IDX_W-1:0] REG_Y_FLOOR      = 3'd3;
    localparam logic [IDX_W-1:0] REG_Y_CEILING    = 3'd4;
    localparam logic [IDX_W-1:0] REG_X_SPAN       = 3'd5;
    localparam logic [IDX_W-1:0] REG_Y_SPAN       = 3'd6;

    localparam logic [CFG_W-1:0] RST_SETTLE_TICKS = 8'd5;
    localparam logic [CFG_W-1:0] RST_X_FLOOR      = 8'd0;
    localparam logic [CFG_W-1:0] RST_X_CEILING    = 8'd255;
    localparam logic [CFG_W-1:0] RST_Y_FLOOR      = 8'd0;
    localparam logic [CFG_W-1:0] RST_Y_CEILING    = 8'd255;
    localparam logic [CFG_W-1:0] RST_X_SPAN       = 8'd155;
    localparam logic [CFG_W-1:0] RST_Y_SPAN       = 8'd105;

    // pin drive patterns: bit0 left, bit1 right, bit2 top, bit3 bottom
    localparam logic [3:0] DIR_DISCHARGE = 4'hF;
    localparam logic [3:0] LVL_DISCHARGE = 4'h0;
    localparam logic [3:0] DIR_X_DRIVE   = 4'h3;
    localparam logic [3:0] LVL_X_DRIVE   = 4'h2;
    localparam logic [3:0] DIR_Y_DRIVE   = 4'hC;
    localparam logic [3:0] LVL_Y_DRIVE   = 4'h8;

    localparam logic [1:0] REQ_NONE = 2'd0;
    localparam logic [1:0] REQ_X    = 2'd1;
    localparam logic [1:0] REQ_Y    = 2'd2;

    localparam logic MODE_TICK = 1'b0;

    typedef enum logic [2:0] {
        PH_DISCHARGE = 3'd0,
        PH_XSETTLE   = 3'd1,
        PH_XCAPTURE  = 3'd2,
        PH_YSETTLE   = 3'd3,
        PH_YCAPTURE  = 3'd4,
        PH_READY     = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_WB,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             mode;
        logic [ADC_W-1:0] adc_value;
    } t_in_item;

    typedef struct packed {
        logic [3:0] pin_direction;
        logic [3:0] pin_level;
        logic [1:0] adc_request;
        logic [2:0] phase;
        logic       coord_valid;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic       cal_error;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] settle_ticks;
        logic [CFG_W-1:0] x_floor;
        logic [CFG_W-1:0] x_ceiling;
        logic [CFG_W-1:0] y_floor;
        logic [CFG_W-1:0] y_ceiling;
        logic [CFG_W-1:0] x_span;
        logic [CFG_W-1:0] y_span;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic mul;
        logic div_step;
        logic write_coord;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic calc_needed;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

### sv/rtsc_ctrl.sv
module rtsc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  rtsc_pkg::t_status i_status,
    output logic             o_in_ready,
    output rtsc_pkg::t_cmd   o_cmd
);

    rtsc_pkg::t_state r_state;
    rtsc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rtsc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            rtsc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_status.calc_needed ? rtsc_pkg::ST_MUL : rtsc_pkg::ST_EMIT;
                end
            end
            rtsc_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = rtsc_pkg::ST_DIV;
            end
            rtsc_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = rtsc_pkg::ST_WB;
                end
            end
            rtsc_pkg::ST_WB: begin
                o_cmd.write_coord = 1'b1;
                n_state = rtsc_pkg::ST_EMIT;
            end
            rtsc_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = rtsc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rtsc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### sv/rtsc_dp.sv
module rtsc_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rtsc_pkg::t_cfg      i_cfg,
    input  rtsc_pkg::t_in_item  i_in_item,
    input  rtsc_pkg::t_cmd      i_cmd,
    output rtsc_pkg::t_status   o_status,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rtsc_pkg::t_out_item o_out_item
);

    // scan state
    rtsc_pkg::t_phase r_phase;
    rtsc_pkg::t_phase n_phase;
    logic [rtsc_pkg::CFG_W-1:0] r_settle;
    logic [rtsc_pkg::CFG_W-1:0] n_settle;
    logic [7:0] r_x;
    logic [7:0] n_x;
    logic [7:0] r_y;
    logic [7:0] n_y;
    logic r_err;
    logic n_err;

    // calibration operands and serial divider
    logic                        r_axis_y;
    logic [rtsc_pkg::D_W-1:0]    r_d;
    logic [rtsc_pkg::CFG_W-1:0]  r_span;
    logic [rtsc_pkg::CFG_W-1:0]  r_hi;
    logic [rtsc_pkg::PROD_W-1:0] r_quo;
    logic [rtsc_pkg::CFG_W-1:0]  r_rem;
    logic [rtsc_pkg::CNT_W-1:0]  r_cnt;

    rtsc_pkg::t_out_item r_out;
    rtsc_pkg::t_out_item n_out;
    logic                r_out_valid;

    logic [rtsc_pkg::ADC_W-1:0] masked;
    logic [rtsc_pkg::D_W-1:0]   v_ext;
    logic [rtsc_pkg::D_W-1:0]   floor_ext;
    logic [rtsc_pkg::D_W-1:0]   d_val;
    logic                       sel_y;
    logic                       is_tick;
    logic [rtsc_pkg::CFG_W:0]   rem_sh;
    logic                       rem_ge;
    logic [rtsc_pkg::CFG_W-1:0] coord_sat;
    logic                       out_free;

    assign is_tick = (i_in_item.mode == rtsc_pkg::MODE_TICK);
    assign sel_y   = (r_phase == rtsc_pkg::PH_YCAPTURE);

    // reduce the converter result to its upper bits and remove the floor
    always_comb begin
        masked    = i_in_item.adc_value & rtsc_pkg::ADC_MASK;
        v_ext     = rtsc_pkg::D_W'(masked >> rtsc_pkg::DROP_BITS);
        floor_ext = rtsc_pkg::D_W'(sel_y ? i_cfg.y_floor : i_cfg.x_floor);
        d_val     = (v_ext > floor_ext) ? (v_ext - floor_ext) : '0;
    end

    assign o_status.calc_needed = !is_tick && (r_settle == '0) &&
        ((r_phase == rtsc_pkg::PH_XCAPTURE && i_cfg.x_ceiling != '0) ||
         (r_phase == rtsc_pkg::PH_YCAPTURE && i_cfg.y_ceiling != '0));
    assign o_status.div_last = (r_cnt == rtsc_pkg::CNT_W'(rtsc_pkg::PROD_W - 1));
    assign out_free          = !r_out_valid || i_out_ready;
    assign o_status.out_free = out_free;

    // restoring division, one quotient bit a cycle
    always_comb begin
        rem_sh = {r_rem, r_quo[rtsc_pkg::PROD_W-1]};
        rem_ge = (rem_sh >= {1'b0, r_hi});
    end

    assign coord_sat = (r_quo > rtsc_pkg::PROD_W'(r_span)) ? r_span :
                       r_quo[rtsc_pkg::CFG_W-1:0];

    always_comb begin
        n_phase  = r_phase;
        n_settle = r_settle;
        n_x      = r_x;
        n_y      = r_y;
        n_err    = r_err;
        if (i_cmd.accept) begin
            if (is_tick) begin
                case (r_phase)
                    rtsc_pkg::PH_DISCHARGE: begin
                        n_err    = 1'b0;
                        n_settle = i_cfg.settle_ticks;
                        n_phase  = rtsc_pkg::PH_XSETTLE;
                    end
                    rtsc_pkg::PH_XSETTLE: begin
                        if (r_settle > 8'd1) begin
                            n_settle = r_settle - 8'd1;
                        end else begin
                            n_settle = i_cfg.settle_ticks;
                            n_phase  = rtsc_pkg::PH_XCAPTURE;
                        end
                    end
                    rtsc_pkg::PH_YSETTLE: begin
                        if (r_settle > 8'd1) begin
                            n_settle = r_settle - 8'd1;
                        end else begin
                            n_settle = i_cfg.settle_ticks;
                            n_phase  = rtsc_pkg::PH_YCAPTURE;
                        end
                    end
                    rtsc_pkg::PH_XCAPTURE, rtsc_pkg::PH_YCAPTURE: begin
                        // count down to zero, then the request goes up
                        if (r_settle != '0) begin
                            n_settle = r_settle - 8'd1;
                        end
                    end
                    default: begin
                        n_phase = rtsc_pkg::PH_DISCHARGE;
                    end
                endcase
            end else if (r_settle == '0) begin
                if (r_phase == rtsc_pkg::PH_XCAPTURE) begin
                    n_settle = i_cfg.settle_ticks;
                    n_phase  = rtsc_pkg::PH_YSETTLE;
                    if (i_cfg.x_ceiling == '0) begin
                        n_x   = '0;
                        n_err = 1'b1;
                    end
                end else if (r_phase == rtsc_pkg::PH_YCAPTURE) begin
                    n_settle = '0;
                    n_phase  = rtsc_pkg::PH_READY;
                    if (i_cfg.y_ceiling == '0) begin
                        n_y   = '0;
                        n_err = 1'b1;
                    end
                end
            end
        end else if (i_cmd.write_coord) begin
            if (r_axis_y) begin
                n_y = coord_sat;
            end else begin
                n_x = coord_sat;
            end
        end
    end

    // output transaction built from the state after the item
    always_comb begin
        n_out.pin_direction = rtsc_pkg::DIR_DISCHARGE;
        n_out.pin_level     = rtsc_pkg::LVL_DISCHARGE;
        n_out.adc_request   = rtsc_pkg::REQ_NONE;
        if (r_phase == rtsc_pkg::PH_XCAPTURE) begin
            n_out.pin_direction = rtsc_pkg::DIR_X_DRIVE;
            n_out.pin_level     = rtsc_pkg::LVL_X_DRIVE;
            if (r_settle == '0) begin
                n_out.adc_request = rtsc_pkg::REQ_X;
            end
        end else if (r_phase == rtsc_pkg::PH_YCAPTURE) begin
            n_out.pin_direction = rtsc_pkg::DIR_Y_DRIVE;
            n_out.pin_level     = rtsc_pkg::LVL_Y_DRIVE;
            if (r_settle == '0) begin
                n_out.adc_request = rtsc_pkg::REQ_Y;
            end
        end
        n_out.phase       = r_phase;
        n_out.coord_valid = (r_phase == rtsc_pkg::PH_READY);
        n_out.x_pos       = r_x;
        n_out.y_pos       = r_y;
        n_out.cal_error   = r_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= rtsc_pkg::PH_DISCHARGE;
            r_settle    <= '0;
            r_x         <= '0;
            r_y         <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_settle <= n_settle;
            r_x      <= n_x;
            r_y      <= n_y;
            r_err    <= n_err;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_axis_y <= sel_y;
            r_d      <= d_val;
            r_span   <= sel_y ? i_cfg.y_span : i_cfg.x_span;
            r_hi     <= sel_y ? i_cfg.y_ceiling : i_cfg.x_ceiling;
        end
        if (i_cmd.mul) begin
            r_quo <= rtsc_pkg::PROD_W'(r_d) * rtsc_pkg::PROD_W'(r_span);
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[rtsc_pkg::PROD_W-2:0], rem_ge};
            r_rem <= rem_ge ? rtsc_pkg::CFG_W'(rem_sh - {1'b0, r_hi}) :
                              rem_sh[rtsc_pkg::CFG_W-1:0];
            r_cnt <= r_cnt + rtsc_pkg::CNT_W'(1);
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### sv/resistive_touch_scan_calibrate.sv
// four-wire resistive touch scanner with calibrated X/Y output
// input channel (i_in_valid/o_in_ready/i_in_item): mode 0 is one timer tick,
// mode 1 is a converter result; every accepted item yields exactly one
// output transaction on o_out_valid/i_out_ready/o_out_item
// the output shows pin drive, converter request, scan phase and the held
// coordinates after the item has been applied
// a tick, an ignored converter result or a capture with a zero ceiling goes
// straight to the emit state; any other captured result first passes one
// multiply, 16 steps of the serial divider (one quotient bit a cycle) and a
// write-back; the emit loads the output register and raises o_out_valid
// one item is in flight at a time; the next item is accepted as soon as the
// previous result sits in the output register, even if not yet taken
// if the receiver stalls, the output register holds and the block waits in
// its emit state; nothing is dropped
// the APB port writes the seven calibration registers at 4*index; pready is
// always high; write only while no item is in flight
// reset (i_rst_n low, synchronous) returns to the discharge phase with zero
// coordinates and loads the default calibration values
module resistive_touch_scan_calibrate (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  rtsc_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output rtsc_pkg::t_out_item              o_out_item,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rtsc_pkg::PADDR_W-1:0]     paddr,
    input  logic [rtsc_pkg::PDATA_W-1:0]     pwdata,
    output logic [rtsc_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    rtsc_pkg::t_cfg    r_cfg;
    rtsc_pkg::t_cmd    cmd;
    rtsc_pkg::t_status status;
    logic [rtsc_pkg::IDX_W-1:0] reg_idx;
    logic [rtsc_pkg::CFG_W-1:0] wdata;
    logic                       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[rtsc_pkg::PADDR_W-1:2];
    assign wdata   = pwdata[rtsc_pkg::CFG_W-1:0];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ticks <= rtsc_pkg::RST_SETTLE_TICKS;
            r_cfg.x_floor      <= rtsc_pkg::RST_X_FLOOR;
            r_cfg.x_ceiling    <= rtsc_pkg::RST_X_CEILING;
            r_cfg.y_floor      <= rtsc_pkg::RST_Y_FLOOR;
            r_cfg.y_ceiling    <= rtsc_pkg::RST_Y_CEILING;
            r_cfg.x_span       <= rtsc_pkg::RST_X_SPAN;
            r_cfg.y_span       <= rtsc_pkg::RST_Y_SPAN;
        end else if (wr_en) begin
            case (reg_idx)
                rtsc_pkg::REG_SETTLE_TICKS: r_cfg.settle_ticks <= wdata;
                rtsc_pkg::REG_X_FLOOR:      r_cfg.x_floor      <= wdata;
                rtsc_pkg::REG_X_CEILING:    r_cfg.x_ceiling    <= wdata;
                rtsc_pkg::REG_Y_FLOOR:      r_cfg.y_floor      <= wdata;
                rtsc_pkg::REG_Y_CEILING:    r_cfg.y_ceiling    <= wdata;
                rtsc_pkg::REG_X_SPAN:       r_cfg.x_span       <= wdata;
                rtsc_pkg::REG_Y_SPAN:       r_cfg.y_span       <= wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            rtsc_pkg::REG_SETTLE_TICKS: prdata = rtsc_pkg::PDATA_W'(r_cfg.settle_ticks);
            rtsc_pkg::REG_X_FLOOR:      prdata = rtsc_pkg::PDATA_W'(r_cfg.x_floor);
            rtsc_pkg::REG_X_CEILING:    prdata = rtsc_pkg::PDATA_W'(r_cfg.x_ceiling);
            rtsc_pkg::REG_Y_FLOOR:      prdata = rtsc_pkg::PDATA_W'(r_cfg.y_floor);
            rtsc_pkg::REG_Y_CEILING:    prdata = rtsc_pkg::PDATA_W'(r_cfg.y_ceiling);
            rtsc_pkg::REG_X_SPAN:       prdata = rtsc_pkg::PDATA_W'(r_cfg.x_span);
            rtsc_pkg::REG_Y_SPAN:       prdata = rtsc_pkg::PDATA_W'(r_cfg.y_span);
            default:                    prdata = '0;
        endcase
    end

    rtsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    rtsc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

### dv/resistive_touch_scan_calibrate_tb.sv
module resistive_touch_scan_calibrate_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_ADC = ~rtsc_pkg::MODE_TICK;
    localparam int CALS_PER_PASS = 6;
    localparam int ITEMS_PER_CAL = 58;
    localparam int DRAIN_CYCLES = 25;

    typedef struct packed {
        logic                       is_reg;
        logic                       known;
        logic [rtsc_pkg::IDX_W-1:0] reg_idx;
        logic [rtsc_pkg::CFG_W-1:0] reg_val;
        rtsc_pkg::t_in_item         item;
        rtsc_pkg::t_out_item        exp;
    } t_row;

    logic                           i_clk;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    rtsc_pkg::t_in_item             i_in_item = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    rtsc_pkg::t_out_item            o_out_item;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [rtsc_pkg::PADDR_W-1:0]   paddr = '0;
    logic [rtsc_pkg::PDATA_W-1:0]   pwdata = '0;
    logic [rtsc_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    // predicted scanner state and calibration
    rtsc_pkg::t_cfg                 cal;
    rtsc_pkg::t_phase               scan_ph = rtsc_pkg::PH_DISCHARGE;
    logic [rtsc_pkg::CFG_W-1:0]     settle_left = '0;
    logic [7:0]                     x_held = '0;
    logic [7:0]                     y_held = '0;
    logic                           div_fault = 1'b0;

    rtsc_pkg::t_out_item            pending_reports [$];
    int                             mismatches = 0;
    int                             tx_gap_pct = 10;
    int                             rx_stall_pct = 88;
    t_row                           directed [27];

    resistive_touch_scan_calibrate dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [7:0] calibrate(logic [rtsc_pkg::ADC_W-1:0] raw, logic [7:0] lo,
                                             logic [7:0] hi, logic [7:0] span);
        int v;
        int d;
        int q;
        v = int'((raw & rtsc_pkg::ADC_MASK) >> rtsc_pkg::DROP_BITS);
        d = (v > int'(lo)) ? v - int'(lo) : 0;
        if (hi == 0) begin
            div_fault = 1'b1;
            return 8'd0;
        end
        q = (d * int'(span)) / int'(hi);
        if (q > int'(span)) q = int'(span);
        return q[7:0];
    endfunction

    function automatic rtsc_pkg::t_out_item advance_scan(rtsc_pkg::t_in_item it);
        rtsc_pkg::t_out_item r;
        if (it.mode == rtsc_pkg::MODE_TICK) begin
            case (scan_ph)
                rtsc_pkg::PH_DISCHARGE: begin
                    div_fault = 1'b0;
                    settle_left = cal.settle_ticks;
                    scan_ph = rtsc_pkg::PH_XSETTLE;
                end
                rtsc_pkg::PH_XSETTLE, rtsc_pkg::PH_YSETTLE: begin
                    if (settle_left > 1) begin
                        settle_left--;
                    end else begin
                        settle_left = cal.settle_ticks;
                        if (scan_ph == rtsc_pkg::PH_XSETTLE) scan_ph = rtsc_pkg::PH_XCAPTURE;
                        else scan_ph = rtsc_pkg::PH_YCAPTURE;
                    end
                end
                // ticks while the request is up leave the count at zero
                rtsc_pkg::PH_XCAPTURE, rtsc_pkg::PH_YCAPTURE: begin
                    if (settle_left > 1) settle_left--;
                    else settle_left = '0;
                end
                default: scan_ph = rtsc_pkg::PH_DISCHARGE;
            endcase
        end else if (settle_left == 0) begin
            if (scan_ph == rtsc_pkg::PH_XCAPTURE) begin
                x_held = calibrate(it.adc_value, cal.x_floor, cal.x_ceiling, cal.x_span);
                settle_left = cal.settle_ticks;
                scan_ph = rtsc_pkg::PH_YSETTLE;
            end else if (scan_ph == rtsc_pkg::PH_YCAPTURE) begin
                y_held = calibrate(it.adc_value, cal.y_floor, cal.y_ceiling, cal.y_span);
                settle_left = '0;
                scan_ph = rtsc_pkg::PH_READY;
            end
        end

        r.pin_direction = rtsc_pkg::DIR_DISCHARGE;
        r.pin_level     = rtsc_pkg::LVL_DISCHARGE;
        r.adc_request   = rtsc_pkg::REQ_NONE;
        if (scan_ph == rtsc_pkg::PH_XCAPTURE) begin
            r.pin_direction = rtsc_pkg::DIR_X_DRIVE;
            r.pin_level     = rtsc_pkg::LVL_X_DRIVE;
            if (settle_left == 0) r.adc_request = rtsc_pkg::REQ_X;
        end else if (scan_ph == rtsc_pkg::PH_YCAPTURE) begin
            r.pin_direction = rtsc_pkg::DIR_Y_DRIVE;
            r.pin_level     = rtsc_pkg::LVL_Y_DRIVE;
            if (settle_left == 0) r.adc_request = rtsc_pkg::REQ_Y;
        end
        r.phase       = scan_ph;
        r.coord_valid = (scan_ph == rtsc_pkg::PH_READY);
        r.x_pos       = x_held;
        r.y_pos       = y_held;
        r.cal_error   = div_fault;
        return r;
    endfunction

    function automatic logic [rtsc_pkg::CFG_W-1:0] reg_of(rtsc_pkg::t_cfg c, int idx);
        case (idx)
            rtsc_pkg::REG_SETTLE_TICKS: return c.settle_ticks;
            rtsc_pkg::REG_X_FLOOR:      return c.x_floor;
            rtsc_pkg::REG_X_CEILING:    return c.x_ceiling;
            rtsc_pkg::REG_Y_FLOOR:      return c.y_floor;
            rtsc_pkg::REG_Y_CEILING:    return c.y_ceiling;
            rtsc_pkg::REG_X_SPAN:       return c.x_span;
            default:                    return c.y_span;
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (act !== exp) begin
            $error("%s: expected %0h, actual %0h", name, exp, act);
            mismatches++;
        end
    endfunction

    function automatic t_row reg_row(logic [rtsc_pkg::IDX_W-1:0] idx,
                                     logic [rtsc_pkg::CFG_W-1:0] val);
        t_row r;
        r = '0;
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_row step_row(logic mode, logic [rtsc_pkg::ADC_W-1:0] adc);
        t_row r;
        r = '0;
        r.item.mode      = mode;
        r.item.adc_value = adc;
        return r;
    endfunction

    // discharge-pin phases only, so pins and request follow from the phase
    function automatic t_row known_row(logic mode, logic [rtsc_pkg::ADC_W-1:0] adc,
                                       rtsc_pkg::t_phase ph, logic [7:0] x, logic [7:0] y,
                                       logic err);
        t_row r;
        r = step_row(mode, adc);
        r.known             = 1'b1;
        r.exp.pin_direction = rtsc_pkg::DIR_DISCHARGE;
        r.exp.pin_level     = rtsc_pkg::LVL_DISCHARGE;
        r.exp.adc_request   = rtsc_pkg::REQ_NONE;
        r.exp.phase         = ph;
        r.exp.coord_valid   = (ph == rtsc_pkg::PH_READY);
        r.exp.x_pos         = x;
        r.exp.y_pos         = y;
        r.exp.cal_error     = err;
        return r;
    endfunction

    function automatic rtsc_pkg::t_in_item next_touch_item();
        rtsc_pkg::t_in_item it;
        logic [7:0] lo;
        logic [7:0] hi;
        logic awaiting;
        it.mode = rtsc_pkg::MODE_TICK;
        it.adc_value = rtsc_pkg::ADC_W'($urandom);
        awaiting = (scan_ph == rtsc_pkg::PH_XCAPTURE || scan_ph == rtsc_pkg::PH_YCAPTURE) &&
                   settle_left == 0;
        lo = (scan_ph == rtsc_pkg::PH_YCAPTURE) ? cal.y_floor : cal.x_floor;
        hi = (scan_ph == rtsc_pkg::PH_YCAPTURE) ? cal.y_ceiling : cal.x_ceiling;
        if ($urandom_range(99) < 15) begin
            it.mode = 1'($urandom);
        end else if (awaiting) begin
            it.mode = MODE_ADC;
            case ($urandom_range(3))
                1: it.adc_value = {lo, 4'($urandom)};
                2: it.adc_value = {hi, 4'($urandom)};
                3: it.adc_value = $urandom_range(1) ? 12'hFFF : 12'h000;
                default: ;
            endcase
        end
        return it;
    endfunction

    task automatic write_reg(logic [rtsc_pkg::IDX_W-1:0] idx, logic [rtsc_pkg::CFG_W-1:0] val);
        paddr   = rtsc_pkg::PADDR_W'({idx, 2'b00});
        pwdata  = rtsc_pkg::PDATA_W'(val);
        pwrite  = 1'b1;
        psel    = 1'b1;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        case (idx)
            rtsc_pkg::REG_SETTLE_TICKS: cal.settle_ticks = val;
            rtsc_pkg::REG_X_FLOOR:      cal.x_floor = val;
            rtsc_pkg::REG_X_CEILING:    cal.x_ceiling = val;
            rtsc_pkg::REG_Y_FLOOR:      cal.y_floor = val;
            rtsc_pkg::REG_Y_CEILING:    cal.y_ceiling = val;
            rtsc_pkg::REG_X_SPAN:       cal.x_span = val;
            default:                    cal.y_span = val;
        endcase
    endtask

    task automatic check_regs();
        logic [rtsc_pkg::PDATA_W-1:0] data;
        for (int i = rtsc_pkg::REG_SETTLE_TICKS; i <= rtsc_pkg::REG_Y_SPAN; i++) begin
            paddr   = rtsc_pkg::PADDR_W'({rtsc_pkg::IDX_W'(i), 2'b00});
            pwrite  = 1'b0;
            psel    = 1'b1;
            penable = 1'b0;
            @(negedge i_clk);
            penable = 1'b1;
            do @(posedge i_clk); while (!pready);
            data = prdata;
            @(negedge i_clk);
            psel    = 1'b0;
            penable = 1'b0;
            check_field($sformatf("register %0d", i),
                        rtsc_pkg::PDATA_W'(reg_of(cal, i)), data);
        end
    endtask

    task automatic wait_idle();
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // returns at the falling edge after the transaction, valid still high
    task automatic put_item(rtsc_pkg::t_in_item it, logic known,
                            rtsc_pkg::t_out_item known_exp);
        int gap;
        rtsc_pkg::t_out_item pred;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < tx_gap_pct) gap++;
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item  = it;
        do @(posedge i_clk); while (!o_in_ready);
        pred = advance_scan(it);
        pending_reports.push_back(known ? known_exp : pred);
        @(negedge i_clk);
    endtask

    task automatic program_calibration(int s);
        rtsc_pkg::t_cfg c;
        c.settle_ticks = 8'($urandom_range(3));
        c.x_floor      = 8'($urandom);
        c.x_ceiling    = 8'($urandom);
        c.y_floor      = 8'($urandom);
        c.y_ceiling    = 8'($urandom);
        c.x_span       = 8'($urandom);
        c.y_span       = 8'($urandom);
        case (s)
            0: c = '{settle_ticks: 8'd1, x_floor: 8'd0, x_ceiling: 8'd255, y_floor: 8'd0,
                     y_ceiling: 8'd255, x_span: 8'd255, y_span: 8'd255};
            1: c.settle_ticks = 8'd255;
            2: c = '{settle_ticks: 8'd0, x_floor: 8'd255, x_ceiling: 8'd255,
                     y_floor: 8'd255, y_ceiling: 8'd255, x_span: 8'd1, y_span: 8'd1};
            4: begin
                c.settle_ticks = 8'd2;
                c.x_ceiling    = 8'd0;
                c.y_ceiling    = 8'd0;
            end
            5: begin
                c.settle_ticks = 8'($urandom_range(3, 1));
                c.x_floor      = 8'($urandom_range(60));
                c.y_floor      = 8'($urandom_range(60));
                c.x_ceiling    = 8'($urandom_range(255, 128));
                c.y_ceiling    = 8'($urandom_range(255, 128));
                c.x_span       = 8'($urandom_range(255, 1));
                c.y_span       = 8'($urandom_range(255, 1));
            end
            default: ;
        endcase
        for (int i = rtsc_pkg::REG_SETTLE_TICKS; i <= rtsc_pkg::REG_Y_SPAN; i++)
            write_reg(rtsc_pkg::IDX_W'(i), reg_of(c, i));
        check_regs();
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        rtsc_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reports.size() == 0) begin
                $error("result transaction with no expectation waiting");
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                check_field("pin_direction", 32'(want.pin_direction),
                            32'(o_out_item.pin_direction));
                check_field("pin_level", 32'(want.pin_level), 32'(o_out_item.pin_level));
                check_field("adc_request", 32'(want.adc_request),
                            32'(o_out_item.adc_request));
                check_field("phase", 32'(want.phase), 32'(o_out_item.phase));
                check_field("coord_valid", 32'(want.coord_valid),
                            32'(o_out_item.coord_valid));
                check_field("x_pos", 32'(want.x_pos), 32'(o_out_item.x_pos));
                check_field("y_pos", 32'(want.y_pos), 32'(o_out_item.y_pos));
                check_field("cal_error", 32'(want.cal_error), 32'(o_out_item.cal_error));
            end
        end
    end

    initial begin
        cal = '{settle_ticks: rtsc_pkg::RST_SETTLE_TICKS, x_floor: rtsc_pkg::RST_X_FLOOR,
                x_ceiling: rtsc_pkg::RST_X_CEILING, y_floor: rtsc_pkg::RST_Y_FLOOR,
                y_ceiling: rtsc_pkg::RST_Y_CEILING, x_span: rtsc_pkg::RST_X_SPAN,
                y_span: rtsc_pkg::RST_Y_SPAN};

        directed = '{
            reg_row(rtsc_pkg::REG_SETTLE_TICKS, 8'd2),
            reg_row(rtsc_pkg::REG_X_CEILING, 8'd100),
            // stray conversion result while discharging
            known_row(MODE_ADC, 12'hFFF, rtsc_pkg::PH_DISCHARGE, 8'd0, 8'd0, 1'b0),
            known_row(rtsc_pkg::MODE_TICK, 12'h000, rtsc_pkg::PH_XSETTLE, 8'd0, 8'd0, 1'b0),
            step_row(rtsc_pkg::MODE_TICK, 12'hFFF),
            step_row(rtsc_pkg::MODE_TICK, 12'h555),
            // result arrives before the capture wait has run out
            step_row(MODE_ADC, 12'h800),
            step_row(rtsc_pkg::MODE_TICK, 12'hAAA),
            step_row(rtsc_pkg::MODE_TICK, 12'h000),
            // tick while the request is raised
            step_row(rtsc_pkg::MODE_TICK, 12'h123),
            // full scale above the ceiling saturates at the span
            known_row(MODE_ADC, 12'hFFF, rtsc_pkg::PH_YSETTLE, 8'd155, 8'd0, 1'b0),
            step_row(rtsc_pkg::MODE_TICK, 12'h000),
            step_row(rtsc_pkg::MODE_TICK, 12'h000),
            step_row(rtsc_pkg::MODE_TICK, 12'h000),
            step_row(rtsc_pkg::MODE_TICK, 12'h000),
            known_row(MODE_ADC, 12'h000, rtsc_pkg::PH_READY, 8'd155, 8'd0, 1'b0),
            known_row(rtsc_pkg::MODE_TICK, 12'h000, rtsc_pkg::PH_DISCHARGE,
                      8'd155, 8'd0, 1'b0),
            // zero settle, zero divisor, zero span
            reg_row(rtsc_pkg::REG_SETTLE_TICKS, 8'd0),
            reg_row(rtsc_pkg::REG_X_CEILING, 8'd0),
            reg_row(rtsc_pkg::REG_Y_SPAN, 8'd0),
            known_row(rtsc_pkg::MODE_TICK, 12'h000, rtsc_pkg::PH_XSETTLE,
                      8'd155, 8'd0, 1'b0),
            step_row(rtsc_pkg::MODE_TICK, 12'h000),
            known_row(MODE_ADC, 12'hABC, rtsc_pkg::PH_YSETTLE, 8'd0, 8'd0, 1'b1),
            step_row(rtsc_pkg::MODE_TICK, 12'h000),
            known_row(MODE_ADC, 12'hFFF, rtsc_pkg::PH_READY, 8'd0, 8'd0, 1'b1),
            known_row(rtsc_pkg::MODE_TICK, 12'h000, rtsc_pkg::PH_DISCHARGE,
                      8'd0, 8'd0, 1'b1),
            // error flag clears as the next scan starts
            known_row(rtsc_pkg::MODE_TICK, 12'h000, rtsc_pkg::PH_XSETTLE, 8'd0, 8'd0, 1'b0)
        };

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        check_regs();

        foreach (directed[r]) begin
            if (directed[r].is_reg) begin
                i_in_valid = 1'b0;
                wait_idle();
                write_reg(directed[r].reg_idx, directed[r].reg_val);
            end else begin
                put_item(directed[r].item, directed[r].known, directed[r].exp);
            end
        end

        for (int m = 0; m < 3; m++) begin
            case (m)
                0: begin tx_gap_pct = 10; rx_stall_pct = 88; end
                1: begin tx_gap_pct = 88; rx_stall_pct = 10; end
                default: begin tx_gap_pct = 0; rx_stall_pct = 0; end
            endcase
            for (int s = 0; s < CALS_PER_PASS; s++) begin
                i_in_valid = 1'b0;
                wait_idle();
                program_calibration(s);
                for (int n = 0; n < ITEMS_PER_CAL; n++) begin
                    // hold the sender off until the output side has drained
                    if (n == ITEMS_PER_CAL / 2) begin
                        i_in_valid = 1'b0;
                        wait_idle();
                    end
                    put_item(next_touch_item(), 1'b0, '0);
                end
            end
        end

        i_in_valid = 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### resistive_touch_scan_calibrate.f
sv/rtsc_pkg.sv
sv/rtsc_ctrl.sv
sv/rtsc_dp.sv
sv/resistive_touch_scan_calibrate.sv
dv/resistive_touch_scan_calibrate_tb.sv
